// File: sv/eihp_pkg.sv
// Package with the types, codes and lookup functions shared by the header parser.
package eihp_pkg;

  localparam int MaxFrameBytes = 16384;
  localparam int PosW = 15;
  localparam int QueueDepth = 2;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT_MAC   = 4'd1,
    ST_UNKNOWN_NET = 4'd2,
    ST_IPV6        = 4'd3,
    ST_SHORT_IPV4  = 4'd4,
    ST_SHORT_ARP   = 4'd5,
    ST_ARP_DONE    = 4'd6,
    ST_UNKNOWN_TR  = 4'd7,
    ST_SHORT_ICMP  = 4'd8,
    ST_SHORT_TCP   = 4'd9,
    ST_SHORT_UDP   = 4'd10,
    ST_BAD_IHL     = 4'd11
  } status_t;

  localparam logic [1:0] NET_UNKNOWN = 2'd0;
  localparam logic [1:0] NET_IPV4    = 2'd1;
  localparam logic [1:0] NET_IPV6    = 2'd2;
  localparam logic [1:0] NET_ARP     = 2'd3;

  localparam logic [1:0] TR_UNKNOWN = 2'd0;
  localparam logic [1:0] TR_ICMP    = 2'd1;
  localparam logic [1:0] TR_TCP     = 2'd2;
  localparam logic [1:0] TR_UDP     = 2'd3;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [15:0] ETH_ARP  = 16'h0806;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  network_kind;
    logic [1:0]  transport_kind;
    logic [47:0] source_mac;
    logic [47:0] dest_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] ip_payload_len;
    logic [15:0] src_l4_port;
    logic [15:0] dest_port;
    logic [5:0]  tcp_flag_bits;
    logic [3:0]  message_class;
  } out_item_t;

  // Snapshot of one finished frame, handed from the capture side to the decoder.
  typedef struct packed {
    logic [PosW-1:0] frame_len;
    logic [15:0]     ether_kind;
    logic [47:0]     src_mac;
    logic [47:0]     dst_mac;
    logic [3:0]      ihl;
    logic [15:0]     total_len;
    logic [7:0]      protocol;
    logic [31:0]     src_ip;
    logic [31:0]     dst_ip;
    logic [15:0]     src_port;
    logic [15:0]     dst_port;
    logic [5:0]      flags;
    logic [15:0]     message;
  } frame_snap_t;

  function automatic logic [3:0] icmp_class(input logic [7:0] kind);
    logic [3:0] c;
    begin
      unique case (kind)
        8'd0:  c = 4'd0;
        8'd3:  c = 4'd1;
        8'd4:  c = 4'd2;
        8'd5:  c = 4'd3;
        8'd8:  c = 4'd4;
        8'd11: c = 4'd5;
        8'd12: c = 4'd6;
        8'd13: c = 4'd7;
        8'd14: c = 4'd8;
        8'd15: c = 4'd9;
        8'd16: c = 4'd10;
        8'd17: c = 4'd11;
        8'd18: c = 4'd12;
        default: c = 4'd13;
      endcase
      return c;
    end
  endfunction

  function automatic logic [3:0] arp_class(input logic [15:0] op);
    logic [3:0] c;
    begin
      unique case (op)
        16'd1:  c = 4'd0;
        16'd2:  c = 4'd1;
        16'd3:  c = 4'd2;
        16'd4:  c = 4'd3;
        16'd8:  c = 4'd4;
        16'd9:  c = 4'd5;
        16'd10: c = 4'd6;
        default: c = 4'd7;
      endcase
      return c;
    end
  endfunction

endpackage

// File: sv/eihp_capture.sv
// Front end: counts frame bytes and captures header fields by position.
module eihp_capture (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  eihp_pkg::in_item_t   in_data,
  output logic                 snap_valid,
  input  logic                 snap_ready,
  output eihp_pkg::frame_snap_t snap_data
);
  import eihp_pkg::*;

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [15:0] ek_r, ek_nxt;
  logic [47:0] smac_r, smac_nxt, dmac_r, dmac_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [15:0] tl_r, tl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] sip_r, sip_nxt, dip_r, dip_nxt;
  logic [15:0] sp_r, sp_nxt, dp_r, dp_nxt;
  logic [5:0]  fl_r, fl_nxt;
  logic [15:0] msg_r, msg_nxt;

  logic            fire, keep;
  logic [PosW-1:0] pos_inc, t_start, off;
  logic [7:0]      b;

  assign in_ready   = snap_ready;
  assign fire       = in_valid & in_ready;
  assign snap_valid = fire & in_data.frame_end;
  assign b          = in_data.data_byte;
  assign keep       = pos_r < PosW'(MaxFrameBytes);
  assign pos_inc    = keep ? pos_r + PosW'(1) : pos_r;
  assign t_start    = PosW'(14) + {{(PosW-6){1'b0}}, ihl_r, 2'b00};
  assign off        = pos_r - t_start;

  always_comb begin
    pos_nxt = pos_r; ek_nxt = ek_r; smac_nxt = smac_r; dmac_nxt = dmac_r;
    ihl_nxt = ihl_r; tl_nxt = tl_r; proto_nxt = proto_r; sip_nxt = sip_r;
    dip_nxt = dip_r; sp_nxt = sp_r; dp_nxt = dp_r; fl_nxt = fl_r; msg_nxt = msg_r;
    if (fire && keep) begin
      pos_nxt = pos_inc;
      if (pos_r < PosW'(6)) begin
        dmac_nxt = {dmac_r[39:0], b};
      end else if (pos_r < PosW'(12)) begin
        smac_nxt = {smac_r[39:0], b};
      end else if (pos_r < PosW'(14)) begin
        ek_nxt = {ek_r[7:0], b};
      end else if (ek_r == ETH_IPV4) begin
        if (pos_r == PosW'(14)) ihl_nxt = b[3:0];
        else if (pos_r == PosW'(16) || pos_r == PosW'(17)) tl_nxt = {tl_r[7:0], b};
        else if (pos_r == PosW'(23)) proto_nxt = b;
        else if (pos_r >= PosW'(26) && pos_r < PosW'(30)) sip_nxt = {sip_r[23:0], b};
        else if (pos_r >= PosW'(30) && pos_r < PosW'(34)) dip_nxt = {dip_r[23:0], b};
        if (pos_r > PosW'(14) && ihl_r >= 4'd5 && pos_r >= t_start) begin
          if (off < PosW'(2)) sp_nxt = {sp_r[7:0], b};
          else if (off < PosW'(4)) dp_nxt = {dp_r[7:0], b};
          if (off == PosW'(0)) msg_nxt = {8'd0, b};
          if (off == PosW'(13)) fl_nxt = b[5:0];
        end
      end else if (ek_r == ETH_ARP) begin
        if (pos_r == PosW'(20) || pos_r == PosW'(21)) msg_nxt = {msg_r[7:0], b};
      end
    end
    if (snap_valid) begin
      pos_nxt = '0; ek_nxt = '0; smac_nxt = '0; dmac_nxt = '0; ihl_nxt = '0;
      tl_nxt = '0; proto_nxt = '0; sip_nxt = '0; dip_nxt = '0; sp_nxt = '0;
      dp_nxt = '0; fl_nxt = '0; msg_nxt = '0;
    end
  end

  // Snapshot carries this byte's contribution as well.
  always_comb begin
    snap_data = '{frame_len: pos_inc, ether_kind: ek_nxt, src_mac: smac_nxt,
                  dst_mac: dmac_nxt, ihl: ihl_nxt, total_len: tl_nxt,
                  protocol: proto_nxt, src_ip: sip_nxt, dst_ip: dip_nxt,
                  src_port: sp_nxt, dst_port: dp_nxt, flags: fl_nxt,
                  message: msg_nxt};
    if (snap_valid) begin
      snap_data = '{frame_len: pos_inc, ether_kind: ek_r, src_mac: smac_r,
                    dst_mac: dmac_r, ihl: ihl_r, total_len: tl_r,
                    protocol: proto_r, src_ip: sip_r, dst_ip: dip_r,
                    src_port: sp_r, dst_port: dp_r, flags: fl_r, message: msg_r};
      if (keep) begin
        if (pos_r < PosW'(6)) snap_data.dst_mac = {dmac_r[39:0], b};
        else if (pos_r < PosW'(12)) snap_data.src_mac = {smac_r[39:0], b};
        else if (pos_r < PosW'(14)) snap_data.ether_kind = {ek_r[7:0], b};
        else if (ek_r == ETH_IPV4) begin
          if (pos_r == PosW'(14)) snap_data.ihl = b[3:0];
          else if (pos_r == PosW'(16) || pos_r == PosW'(17)) snap_data.total_len = {tl_r[7:0], b};
          else if (pos_r == PosW'(23)) snap_data.protocol = b;
          else if (pos_r >= PosW'(26) && pos_r < PosW'(30)) snap_data.src_ip = {sip_r[23:0], b};
          else if (pos_r >= PosW'(30) && pos_r < PosW'(34)) snap_data.dst_ip = {dip_r[23:0], b};
          if (pos_r > PosW'(14) && ihl_r >= 4'd5 && pos_r >= t_start) begin
            if (off < PosW'(2)) snap_data.src_port = {sp_r[7:0], b};
            else if (off < PosW'(4)) snap_data.dst_port = {dp_r[7:0], b};
            if (off == PosW'(0)) snap_data.message = {8'd0, b};
            if (off == PosW'(13)) snap_data.flags = b[5:0];
          end
        end else if (ek_r == ETH_ARP) begin
          if (pos_r == PosW'(20) || pos_r == PosW'(21)) snap_data.message = {msg_r[7:0], b};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; ek_r <= '0; smac_r <= '0; dmac_r <= '0; ihl_r <= '0;
      tl_r <= '0; proto_r <= '0; sip_r <= '0; dip_r <= '0; sp_r <= '0;
      dp_r <= '0; fl_r <= '0; msg_r <= '0;
    end else begin
      pos_r <= pos_nxt; ek_r <= ek_nxt; smac_r <= smac_nxt; dmac_r <= dmac_nxt;
      ihl_r <= ihl_nxt; tl_r <= tl_nxt; proto_r <= proto_nxt; sip_r <= sip_nxt;
      dip_r <= dip_nxt; sp_r <= sp_nxt; dp_r <= dp_nxt; fl_r <= fl_nxt;
      msg_r <= msg_nxt;
    end
  end

endmodule

// File: sv/eihp_queue.sv
// Short queue of frame snapshots between the capture and decode sides.
module eihp_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  eihp_pkg::frame_snap_t wr_data,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output eihp_pkg::frame_snap_t rd_data
);
  import eihp_pkg::*;

  frame_snap_t      mem_r [QueueDepth];
  logic [QPtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = cnt_r != QCntW'(QueueDepth);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) wp_nxt = (wp_r == QPtrW'(QueueDepth - 1)) ? '0 : wp_r + QPtrW'(1);
    if (pop) rp_nxt = (rp_r == QPtrW'(QueueDepth - 1)) ? '0 : rp_r + QPtrW'(1);
    cnt_nxt = cnt_r + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: sv/eihp_decode.sv
// Back end: checks layer lengths, builds the status and fields, holds the result.
module eihp_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  snap_valid,
  output logic                  snap_ready,
  input  eihp_pkg::frame_snap_t snap_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output eihp_pkg::out_item_t   out_data
);
  import eihp_pkg::*;

  logic        valid_r, valid_nxt;
  out_item_t   res_r, res_nxt, r;
  logic [PosW-1:0] rest, hl, avail;
  logic [1:0]  tk;
  logic [15:0] hl16;

  assign snap_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_data   = res_r;

  always_comb begin
    r     = '0;
    rest  = snap_data.frame_len - PosW'(14);
    hl    = {{(PosW-6){1'b0}}, snap_data.ihl, 2'b00};
    hl16  = {10'd0, snap_data.ihl, 2'b00};
    avail = rest - hl;
    unique case (snap_data.protocol)
      PROTO_ICMP: tk = TR_ICMP;
      PROTO_TCP:  tk = TR_TCP;
      PROTO_UDP:  tk = TR_UDP;
      default:    tk = TR_UNKNOWN;
    endcase
    if (snap_data.frame_len < PosW'(14)) begin
      r.status = ST_SHORT_MAC;
    end else begin
      r.source_mac = snap_data.src_mac;
      r.dest_mac   = snap_data.dst_mac;
      if (snap_data.ether_kind == ETH_IPV4) begin
        r.network_kind = NET_IPV4;
        if (rest < PosW'(20)) begin
          r.status = ST_SHORT_IPV4;
        end else begin
          r.transport_kind = tk;
          r.source_ip      = snap_data.src_ip;
          r.dest_ip        = snap_data.dst_ip;
          r.ip_payload_len = snap_data.total_len > hl16 ? snap_data.total_len - hl16 : 16'd0;
          if (snap_data.ihl < 4'd5 || hl > rest) r.status = ST_BAD_IHL;
          else if (tk == TR_UNKNOWN) r.status = ST_UNKNOWN_TR;
          else if (tk == TR_ICMP) begin
            if (avail < PosW'(8)) r.status = ST_SHORT_ICMP;
            else r.message_class = icmp_class(snap_data.message[7:0]);
          end else if (tk == TR_TCP) begin
            if (avail < PosW'(20)) r.status = ST_SHORT_TCP;
            else begin
              r.src_l4_port = snap_data.src_port; r.dest_port = snap_data.dst_port;
              r.tcp_flag_bits = snap_data.flags;
            end
          end else begin
            if (avail < PosW'(8)) r.status = ST_SHORT_UDP;
            else begin
              r.src_l4_port = snap_data.src_port; r.dest_port = snap_data.dst_port;
            end
          end
        end
      end else if (snap_data.ether_kind == ETH_IPV6) begin
        r.status = ST_IPV6; r.network_kind = NET_IPV6;
      end else if (snap_data.ether_kind == ETH_ARP) begin
        r.network_kind = NET_ARP;
        if (rest < PosW'(8)) r.status = ST_SHORT_ARP;
        else begin
          r.status = ST_ARP_DONE; r.message_class = arp_class(snap_data.message);
        end
      end else begin
        r.status = ST_UNKNOWN_NET;
      end
    end
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (snap_ready) begin
      valid_nxt = snap_valid;
      if (snap_valid) res_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

endmodule

// File: sv/ethernet_ipv4_header_parser_unit.sv
// Top level of the Ethernet/IPv4 header parser.
// Throughput: one byte item per clock; the input stalls only if three frame results wait
// unread (two in the snapshot queue, one in the decode output register).
// Result path: the snapshot of a frame's final byte is written into the snapshot queue,
// then decoded into the decode output register.
// Reset: synchronous, active low; clears the byte counter, captured fields,
// queue pointers and the output valid flag.
module ethernet_ipv4_header_parser_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  eihp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output eihp_pkg::out_item_t out_data
);
  import eihp_pkg::*;

  // Front side: each byte advances the counter until it reaches MaxFrameBytes; the final byte emits a snapshot.
  logic        cap_valid, cap_ready, dec_valid, dec_ready;
  frame_snap_t cap_snap, dec_snap;

  eihp_capture u_capture (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .snap_valid(cap_valid), .snap_ready(cap_ready), .snap_data(cap_snap)
  );

  // The queue lets bytes keep flowing while a result waits at the output.
  eihp_queue u_queue (
    .clk, .rst_n,
    .wr_valid(cap_valid), .wr_ready(cap_ready), .wr_data(cap_snap),
    .rd_valid(dec_valid), .rd_ready(dec_ready), .rd_data(dec_snap)
  );

  // Back side: length checks and classification into the output register.
  eihp_decode u_decode (
    .clk, .rst_n,
    .snap_valid(dec_valid), .snap_ready(dec_ready), .snap_data(dec_snap),
    .out_valid, .out_ready, .out_data
  );

endmodule

// File: sv/eihp_checker.sv
// Port-level checker for the header parser, bound to the top level.
module eihp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input eihp_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input eihp_pkg::out_item_t out_data
);
  import eihp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= 4'(ST_BAD_IHL))
    else $error("status out of range");

  a_short_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == 4'(ST_SHORT_MAC) |->
      out_data.source_mac == '0 && out_data.network_kind == NET_UNKNOWN)
    else $error("short frame carries fields");

  a_flags_only_tcp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tcp_flag_bits != '0 |->
      out_data.status == 4'(ST_OK) && out_data.transport_kind == TR_TCP)
    else $error("flags outside good tcp");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.frame_end, 2))
    else $error("result without frame end");

endmodule

bind ethernet_ipv4_header_parser_unit eihp_checker u_eihp_checker (
  .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
);
